@@ sv/yrp_pkg.sv @@
// Shared widths, register indexes, constants and sequencer states of the yaw rate PID.
package yrp_pkg;

  localparam int STICK_W   = 12;
  localparam int THR_W     = 12;
  localparam int GYRO_W    = 16;
  localparam int DRIVE_W   = 16;
  localparam int CMD_W     = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STICK_CENTER = 3'd0,
    REG_YAW_DEADBAND = 3'd1,
    REG_YAW_RATE     = 3'd2,
    REG_P_GAIN       = 3'd3,
    REG_I_GAIN       = 3'd4,
    REG_D_GAIN       = 3'd5,
    REG_CLAMP_ENABLE = 3'd6
  } reg_index_t;

  localparam logic [10:0] STICK_CENTER_RST = 11'd1500;
  localparam logic [7:0]  P_GAIN_RST       = 8'd85;
  localparam logic [7:0]  I_GAIN_RST       = 8'd45;

  localparam logic [8:0]         STICK_LIMIT  = 9'd500;
  localparam logic [THR_W-1:0]   THROTTLE_LOW = 12'd1300;
  localparam logic signed [18:0] I_LIMIT      = 19'sd16000;
  localparam logic [15:0]        GYRO_LIMIT   = 16'd640;
  localparam logic [8:0]         RATE_DIV     = 9'd500;
  localparam logic [8:0]         PCT_DIV      = 9'd100;
  localparam logic [7:0]         PCT_FULL     = 8'd100;
  localparam logic [8:0]         I_DIV        = 9'd125;
  localparam logic [8:0]         P_DIV        = 9'd80;
  localparam logic signed [19:0] DRIVE_MAX    = 20'sd32767;
  localparam logic signed [19:0] DRIVE_MIN    = -20'sd32768;
  localparam logic signed [15:0] DRIVE_CLAMP  = 16'sd200;
  localparam logic [CNT_W-1:0]   MUL_STEPS    = 5'd8;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PREP,
    S_MRATE,
    S_DRATE,
    S_MP,
    S_DP,
    S_MD,
    S_DD,
    S_DERR,
    S_INTEG,
    S_LDI,
    S_DINT,
    S_MI,
    S_MG,
    S_DG,
    S_MDS,
    S_SUM
  } state_t;

endpackage

@@ sv/yrp_if.sv @@
// Request and result channel interfaces of the yaw rate PID.
interface yrp_sample_if;
  import yrp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STICK_W-1:0]       yaw_stick;
  logic [THR_W-1:0]         throttle_raw;
  logic signed [GYRO_W-1:0] gyro_yaw;
  logic                     armed;
  modport source (output valid, yaw_stick, throttle_raw, gyro_yaw, armed, input ready);
  modport sink   (input valid, yaw_stick, throttle_raw, gyro_yaw, armed, output ready);
endinterface

interface yrp_result_if;
  import yrp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] yaw_drive;
  logic signed [CMD_W-1:0]   yaw_command;
  modport source (output valid, yaw_drive, yaw_command, input ready);
  modport sink   (input valid, yaw_drive, yaw_command, output ready);
endinterface

@@ sv/yaw_rate_pid_with_stick_gain.sv @@
// Yaw rate PID with stick dependent gain: sequencer and bit-serial datapath.
//
// One request on the sample channel carries yaw stick, throttle, yaw gyro and
// the arm flag of one control cycle; one result (yaw_drive, yaw_command)
// leaves on the result channel for every request. Gains and stick shaping
// come from seven registers on the cfg_we / cfg_index / cfg_data write port;
// the user must write them only while no request is in flight (not enforced).
// All products and quotients run through one shift-add multiplier and one
// restoring divider (one quotient bit per cycle), used in turn by twelve
// operations. result.valid rises at the same edge as sample.ready, and a new
// request is taken only once the previous one has left the final sum.
// The result sits in an output register: a stalled receiver does not hold
// up the next request, which runs up to the final sum and waits there until
// the previous result is taken.
// rst (synchronous) restores register defaults, clears the integrator, the
// gyro history and the pending clear, and drops result.valid.
module yaw_rate_pid_with_stick_gain (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [yrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [yrp_pkg::CFG_W-1:0]     cfg_data,
  yrp_sample_if.sink                    sample,
  yrp_result_if.source                  result
);
  import yrp_pkg::*;

  function automatic logic [15:0] abs16(input logic [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

  // configuration
  logic [10:0] stick_center;
  logic [6:0]  yaw_deadband;
  logic [6:0]  yaw_rate;
  logic [7:0]  p_gain;
  logic [7:0]  i_gain;
  logic [6:0]  d_gain;
  logic        clamp_enable;

  // control
  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              res_valid, res_valid_next;

  // loop state
  logic signed [14:0] rate_integrator, rate_integrator_next;
  logic signed [15:0] previous_gyro, previous_gyro_next;
  logic signed [15:0] delta_back_one, delta_back_one_next;
  logic signed [15:0] delta_back_two, delta_back_two_next;
  logic               clear_pending, clear_pending_next;

  // serial engine
  logic [23:0] acc, acc_next;
  logic [23:0] mcand, mcand_next;
  logic [7:0]  mplier, mplier_next;
  logic [23:0] dq, dq_next;
  logic [8:0]  rem, rem_next;
  logic [8:0]  dvsr, dvsr_next;

  // per request operands and terms
  logic signed [12:0] dev, dev_next;
  logic signed [15:0] gyro, gyro_next;
  logic [15:0]        gyro_mag, gyro_mag_next;
  logic               gyro_big, gyro_big_next;
  logic signed [15:0] dsum, dsum_next;
  logic [8:0]         mag, mag_next;
  logic               cmd_neg, cmd_neg_next;
  logic signed [9:0]  cmd, cmd_next;
  logic [6:0]         factor, factor_next;
  logic [7:0]         dyn_p, dyn_p_next;
  logic [6:0]         dyn_d, dyn_d_next;
  logic signed [17:0] err, err_next;
  logic signed [10:0] iterm, iterm_next;
  logic signed [18:0] pterm, pterm_next;
  logic signed [18:0] dterm, dterm_next;
  logic signed [15:0] drive_q, drive_q_next;
  logic signed [9:0]  cmd_q, cmd_q_next;

  // combinational temporaries
  logic [10:0]        trial;
  logic               div_ge;
  logic signed [15:0] delta;
  logic               thr_low;
  logic [11:0]        abs_dev;
  logic [8:0]         lim;
  logic [8:0]         mag_t;
  logic [6:0]         factor_t;
  logic [15:0]        err_dividend;
  logic signed [17:0] qs;
  logic signed [18:0] sum_i;
  logic [14:0]        ri_mag;
  logic signed [16:0] ps;
  logic signed [18:0] qg;
  logic signed [23:0] dps;
  logic signed [19:0] total;
  logic signed [15:0] sat;

  assign sample.ready       = (state == S_IDLE);
  assign result.valid       = res_valid;
  assign result.yaw_drive   = drive_q;
  assign result.yaw_command = cmd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_center <= STICK_CENTER_RST;
      yaw_deadband <= '0;
      yaw_rate     <= '0;
      p_gain       <= P_GAIN_RST;
      i_gain       <= I_GAIN_RST;
      d_gain       <= '0;
      clamp_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STICK_CENTER: stick_center <= cfg_data[10:0];
        REG_YAW_DEADBAND: yaw_deadband <= cfg_data[6:0];
        REG_YAW_RATE:     yaw_rate     <= cfg_data[6:0];
        REG_P_GAIN:       p_gain       <= cfg_data[7:0];
        REG_I_GAIN:       i_gain       <= cfg_data[7:0];
        REG_D_GAIN:       d_gain       <= cfg_data[6:0];
        REG_CLAMP_ENABLE: clamp_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cnt             <= '0;
      res_valid       <= 1'b0;
      rate_integrator <= '0;
      previous_gyro   <= '0;
      delta_back_one  <= '0;
      delta_back_two  <= '0;
      clear_pending   <= 1'b0;
    end else begin
      state           <= state_next;
      cnt             <= cnt_next;
      res_valid       <= res_valid_next;
      rate_integrator <= rate_integrator_next;
      previous_gyro   <= previous_gyro_next;
      delta_back_one  <= delta_back_one_next;
      delta_back_two  <= delta_back_two_next;
      clear_pending   <= clear_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    acc      <= acc_next;
    mcand    <= mcand_next;
    mplier   <= mplier_next;
    dq       <= dq_next;
    rem      <= rem_next;
    dvsr     <= dvsr_next;
    dev      <= dev_next;
    gyro     <= gyro_next;
    gyro_mag <= gyro_mag_next;
    gyro_big <= gyro_big_next;
    dsum     <= dsum_next;
    mag      <= mag_next;
    cmd_neg  <= cmd_neg_next;
    cmd      <= cmd_next;
    factor   <= factor_next;
    dyn_p    <= dyn_p_next;
    dyn_d    <= dyn_d_next;
    err      <= err_next;
    iterm    <= iterm_next;
    pterm    <= pterm_next;
    dterm    <= dterm_next;
    drive_q  <= drive_q_next;
    cmd_q    <= cmd_q_next;
  end

  always_comb begin
    state_next           = state;
    cnt_next             = cnt;
    res_valid_next       = res_valid && !result.ready;
    rate_integrator_next = rate_integrator;
    previous_gyro_next   = previous_gyro;
    delta_back_one_next  = delta_back_one;
    delta_back_two_next  = delta_back_two;
    clear_pending_next   = clear_pending;
    acc_next      = acc;
    mcand_next    = mcand;
    mplier_next   = mplier;
    dq_next       = dq;
    rem_next      = rem;
    dvsr_next     = dvsr;
    dev_next      = dev;
    gyro_next     = gyro;
    gyro_mag_next = gyro_mag;
    gyro_big_next = gyro_big;
    dsum_next     = dsum;
    mag_next      = mag;
    cmd_neg_next  = cmd_neg;
    cmd_next      = cmd;
    factor_next   = factor;
    dyn_p_next    = dyn_p;
    dyn_d_next    = dyn_d;
    err_next      = err;
    iterm_next    = iterm;
    pterm_next    = pterm;
    dterm_next    = dterm;
    drive_q_next  = drive_q;
    cmd_q_next    = cmd_q;

    trial        = {1'b0, rem, dq[23]} - {2'b00, dvsr};
    div_ge       = !trial[10];
    delta        = sample.gyro_yaw - previous_gyro;
    thr_low      = sample.throttle_raw < THROTTLE_LOW;
    abs_dev      = dev[12] ? 12'(-dev) : 12'(dev);
    lim          = (abs_dev > {3'b000, STICK_LIMIT}) ? STICK_LIMIT : abs_dev[8:0];
    mag_t        = (lim > {2'b00, yaw_deadband}) ? (lim - {2'b00, yaw_deadband}) : 9'd0;
    factor_t     = (dq[7:0] >= PCT_FULL) ? 7'd0 : 7'(PCT_FULL - dq[7:0]);
    err_dividend = {1'b0, mag, 6'd0} + {3'b000, mag, 4'd0};
    qs           = $signed({2'b00, dq[15:0]});
    sum_i        = {{4{rate_integrator[14]}}, rate_integrator} + {err[17], err};
    ri_mag       = rate_integrator[14] ? 15'(-rate_integrator) : 15'(rate_integrator);
    ps           = rate_integrator[14] ? -$signed({2'b00, acc[14:0]})
                                       : $signed({2'b00, acc[14:0]});
    qg           = gyro[15] ? -$signed({2'b00, dq[16:0]}) : $signed({2'b00, dq[16:0]});
    dps          = dsum[15] ? -$signed({1'b0, acc[22:0]}) : $signed({1'b0, acc[22:0]});
    total        = {pterm[18], pterm} + {{9{iterm[10]}}, iterm} - {dterm[18], dterm};
    if (total > DRIVE_MAX) begin
      sat = DRIVE_MAX[15:0];
    end else if (total < DRIVE_MIN) begin
      sat = DRIVE_MIN[15:0];
    end else begin
      sat = total[15:0];
    end
    if (clamp_enable && (sat > DRIVE_CLAMP)) begin
      sat = DRIVE_CLAMP;
    end else if (clamp_enable && (sat < -DRIVE_CLAMP)) begin
      sat = -DRIVE_CLAMP;
    end

    // one multiplier bit and one quotient bit per cycle
    if (cnt != '0) begin
      acc_next    = acc + (mplier[0] ? mcand : 24'd0);
      mcand_next  = {mcand[22:0], 1'b0};
      mplier_next = {1'b0, mplier[7:1]};
      rem_next    = div_ge ? trial[8:0] : {rem[7:0], dq[23]};
      dq_next     = {dq[22:0], div_ge};
      cnt_next    = cnt - 5'd1;
    end

    case (state)
      S_IDLE: begin
        if (sample.valid) begin
          dev_next            = $signed({1'b0, sample.yaw_stick}) -
                                $signed({2'b00, stick_center});
          gyro_next           = sample.gyro_yaw;
          gyro_mag_next       = abs16(sample.gyro_yaw);
          dsum_next           = delta_back_one + delta_back_two + delta;
          previous_gyro_next  = sample.gyro_yaw;
          delta_back_two_next = delta_back_one;
          delta_back_one_next = delta;
          if (!sample.armed || (clear_pending && thr_low)) begin
            rate_integrator_next = '0;
          end
          clear_pending_next = (!sample.armed || clear_pending) && thr_low;
          state_next         = S_PREP;
        end
      end
      S_PREP: begin
        mag_next      = mag_t;
        cmd_neg_next  = dev[12];
        cmd_next      = dev[12] ? -$signed({1'b0, mag_t}) : $signed({1'b0, mag_t});
        gyro_big_next = gyro_mag > GYRO_LIMIT;
        acc_next      = '0;
        mcand_next    = {15'd0, mag_t};
        mplier_next   = {1'b0, yaw_rate};
        cnt_next      = MUL_STEPS;
        state_next    = S_MRATE;
      end
      S_MRATE: begin
        if (cnt == '0) begin
          rem_next   = '0;
          dvsr_next  = RATE_DIV;
          dq_next    = {acc[15:0], 8'd0};
          cnt_next   = 5'd16;
          state_next = S_DRATE;
        end
      end
      S_DRATE: begin
        if (cnt == '0) begin
          factor_next = factor_t;
          acc_next    = '0;
          mcand_next  = {16'd0, p_gain};
          mplier_next = {1'b0, factor_t};
          cnt_next    = MUL_STEPS;
          state_next  = S_MP;
        end
      end
      S_MP: begin
        if (cnt == '0) begin
          rem_next   = '0;
          dvsr_next  = PCT_DIV;
          dq_next    = {acc[14:0], 9'd0};
          cnt_next   = 5'd15;
          state_next = S_DP;
        end
      end
      S_DP: begin
        if (cnt == '0) begin
          dyn_p_next  = dq[7:0];
          acc_next    = '0;
          mcand_next  = {17'd0, d_gain};
          mplier_next = {1'b0, factor};
          cnt_next    = MUL_STEPS;
          state_next  = S_MD;
        end
      end
      S_MD: begin
        if (cnt == '0) begin
          rem_next   = '0;
          dvsr_next  = PCT_DIV;
          dq_next    = {acc[13:0], 10'd0};
          cnt_next   = 5'd14;
          state_next = S_DD;
        end
      end
      S_DD: begin
        if (cnt == '0) begin
          dyn_d_next = dq[6:0];
          rem_next   = '0;
          dvsr_next  = (p_gain == 8'd0) ? 9'd1 : {1'b0, p_gain};
          dq_next    = {err_dividend, 8'd0};
          cnt_next   = 5'd16;
          state_next = S_DERR;
        end
      end
      S_DERR: begin
        if (cnt == '0) begin
          err_next   = (cmd_neg ? -qs : qs) - $signed({{2{gyro[15]}}, gyro});
          state_next = S_INTEG;
        end
      end
      S_INTEG: begin
        if (gyro_big) begin
          rate_integrator_next = '0;
        end else if (sum_i > I_LIMIT) begin
          rate_integrator_next = I_LIMIT[14:0];
        end else if (sum_i < -I_LIMIT) begin
          rate_integrator_next = 15'(-I_LIMIT);
        end else begin
          rate_integrator_next = sum_i[14:0];
        end
        state_next = S_LDI;
      end
      S_LDI: begin
        rem_next   = '0;
        dvsr_next  = I_DIV;
        dq_next    = {ri_mag[13:0], 10'd0};
        cnt_next   = 5'd14;
        state_next = S_DINT;
      end
      S_DINT: begin
        if (cnt == '0) begin
          acc_next    = '0;
          mcand_next  = {16'd0, dq[7:0]};
          mplier_next = i_gain;
          cnt_next    = MUL_STEPS;
          state_next  = S_MI;
        end
      end
      S_MI: begin
        if (cnt == '0) begin
          iterm_next  = ps[16:6];
          acc_next    = '0;
          mcand_next  = {8'd0, gyro_mag};
          mplier_next = dyn_p;
          cnt_next    = MUL_STEPS;
          state_next  = S_MG;
        end
      end
      S_MG: begin
        if (cnt == '0) begin
          rem_next   = '0;
          dvsr_next  = P_DIV;
          dq_next    = {acc[22:0], 1'b0};
          cnt_next   = 5'd23;
          state_next = S_DG;
        end
      end
      S_DG: begin
        if (cnt == '0) begin
          pterm_next  = $signed({{8{cmd[9]}}, cmd, 1'b0}) - qg;
          acc_next    = '0;
          mcand_next  = {8'd0, abs16(dsum)};
          mplier_next = {1'b0, dyn_d};
          cnt_next    = MUL_STEPS;
          state_next  = S_MDS;
        end
      end
      S_MDS: begin
        if (cnt == '0) begin
          dterm_next = dps[23:5];
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (!res_valid || result.ready) begin
          drive_q_next   = sat;
          cmd_q_next     = cmd;
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_int_bound: assert property (@(posedge clk) disable iff (rst)
    (rate_integrator <= I_LIMIT) && (rate_integrator >= -I_LIMIT))
    else $error("integrator out of range");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    (result.valid && clamp_enable) |->
      ((result.yaw_drive <= DRIVE_CLAMP) && (result.yaw_drive >= -DRIVE_CLAMP)))
    else $error("clamped drive out of range");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state == S_PREP))
    else $error("request accepted without starting");

  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cnt == '0))
    else $error("serial engine busy while idle");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> ($past(state) == S_SUM))
    else $error("result raised outside final sum");

endmodule

@@ tb/tb.sv @@
// Testbench for the yaw rate PID: directed and random control cycles checked against an inline model.
`timescale 1ns / 1ps

module tb;
  import yrp_pkg::*;

  localparam int LONG_HOLD = 1000;

  typedef struct packed {
    logic [STICK_W-1:0]       stick;
    logic [THR_W-1:0]         thr;
    logic signed [GYRO_W-1:0] gyro;
    logic                     arm;
    logic                     drain;
  } yaw_req_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [CMD_W-1:0]   command;
  } yaw_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  yrp_sample_if sample_ch ();
  yrp_result_if result_ch ();

  yaw_rate_pid_with_stick_gain u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  always #4 clk = ~clk;

  // register mirror
  int set_center = STICK_CENTER_RST;
  int set_dband  = 0;
  int set_rate   = 0;
  int set_p      = P_GAIN_RST;
  int set_i      = I_GAIN_RST;
  int set_d      = 0;
  int set_clamp  = 0;

  // PID state mirror
  int m_integ      = 0;
  int m_prev_gyro  = 0;
  int m_delta1     = 0;
  int m_delta2     = 0;
  bit m_clear      = 1'b0;

  yaw_req_t stick_req_q[$];
  yaw_out_t drive_exp_q[$];

  int send_gap_max = 0;
  int recv_gap_max = 0;
  int hold_kicks   = 0;
  int hold_done    = 0;
  int req_cnt      = 0;
  int res_cnt      = 0;
  int fail_cnt     = 0;
  int n_settings   = 1;
  int n_isat       = 0;
  int n_olim       = 0;
  int n_clear      = 0;

  yaw_req_t cur_req = '0;
  bit       tx_on    = 1'b0;
  bit       tx_armed = 1'b0;
  int       tx_gap   = 0;
  int       rx_wait  = 0;
  int       hold_left = 0;

  function automatic int clamp_int(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one control cycle of the PID; updates the state mirror and queues the result
  function automatic void predict_yaw_cycle(yaw_req_t r);
    int stick, thr, g, dev, mag, factor, dyn_p, dyn_d, cmd, pdiv, err, sum;
    int iterm, pterm, delta, dsum, dterm, drive;
    yaw_out_t e;
    stick = r.stick;
    thr   = r.thr;
    g     = $signed(r.gyro);

    dev = stick - set_center;
    mag = (dev < 0) ? -dev : dev;
    if (mag > int'(STICK_LIMIT)) mag = int'(STICK_LIMIT);
    if (mag > set_dband) mag = mag - set_dband;
    else mag = 0;

    factor = int'(PCT_FULL) - set_rate * mag / int'(RATE_DIV);
    if (factor < 0) factor = 0;
    dyn_p = set_p * factor / int'(PCT_DIV);
    dyn_d = set_d * factor / int'(PCT_DIV);
    cmd   = (stick < set_center) ? -mag : mag;

    if (!r.arm) begin
      m_clear = 1'b1;
      m_integ = 0;
    end
    if (m_clear && thr < int'(THROTTLE_LOW)) begin
      m_integ = 0;
      n_clear++;
    end else begin
      m_clear = 1'b0;
    end

    pdiv = (set_p != 0) ? set_p : 1;
    err  = cmd * int'(P_DIV) / pdiv - g;
    sum  = m_integ + err;
    if (sum > int'(I_LIMIT) || sum < -int'(I_LIMIT)) n_isat++;
    m_integ = clamp_int(sum, -int'(I_LIMIT), int'(I_LIMIT));
    if (g > int'(GYRO_LIMIT) || g < -int'(GYRO_LIMIT)) m_integ = 0;
    iterm = (m_integ / int'(I_DIV) * set_i) >>> 6;

    pterm = cmd * 2 - g * dyn_p / 10 / 8;

    delta       = shortint'(g - m_prev_gyro);
    m_prev_gyro = g;
    dsum        = shortint'(m_delta1 + m_delta2 + delta);
    m_delta2    = m_delta1;
    m_delta1    = delta;
    dterm       = (dsum * dyn_d) >>> 5;

    sum   = pterm + iterm - dterm;
    drive = clamp_int(sum, int'(DRIVE_MIN), int'(DRIVE_MAX));
    if (set_clamp != 0) drive = clamp_int(drive, -int'(DRIVE_CLAMP), int'(DRIVE_CLAMP));
    if (drive != sum) n_olim++;

    e.drive   = drive[DRIVE_W-1:0];
    e.command = cmd[CMD_W-1:0];
    drive_exp_q.push_back(e);
  endfunction

  task automatic check_result(logic signed [DRIVE_W-1:0] drv, logic signed [CMD_W-1:0] cmdv);
    yaw_out_t e;
    res_cnt++;
    if (drive_exp_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("result %0d with no request outstanding: drive %0d command %0d",
                 res_cnt, drv, cmdv);
    end else begin
      e = drive_exp_q.pop_front();
      if (drv !== e.drive || cmdv !== e.command) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("result %0d: drive exp %0d got %0d, command exp %0d got %0d", res_cnt,
                   $signed(e.drive), drv, $signed(e.command), cmdv);
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      tx_on = 1'b0;
      tx_armed = 1'b0;
      tx_gap = 0;
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        predict_yaw_cycle(cur_req);
        req_cnt++;
        tx_on = 1'b0;
      end
      if (!tx_on && !tx_armed && stick_req_q.size() != 0) begin
        cur_req = stick_req_q.pop_front();
        tx_gap = $urandom_range(send_gap_max, 0);
        tx_armed = 1'b1;
      end
      if (tx_armed && !(cur_req.drain && drive_exp_q.size() != 0)) begin
        if (tx_gap == 0) begin
          tx_armed = 1'b0;
          tx_on = 1'b1;
        end else if (sample_ch.ready || $urandom_range(15, 0) == 0) begin
          tx_gap--;
        end
      end
      sample_ch.valid        <= tx_on;
      sample_ch.yaw_stick    <= cur_req.stick;
      sample_ch.throttle_raw <= cur_req.thr;
      sample_ch.gyro_yaw     <= cur_req.gyro;
      sample_ch.armed        <= cur_req.arm;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rx_wait = 0;
      hold_left = 0;
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        check_result(result_ch.yaw_drive, result_ch.yaw_command);
        rx_wait = $urandom_range(recv_gap_max, 0);
      end else if (result_ch.valid && rx_wait > 0) begin
        rx_wait--;
      end
      if (hold_kicks != hold_done) begin
        hold_done = hold_kicks;
        hold_left = LONG_HOLD;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      result_ch.ready <= (rx_wait == 0 && hold_left == 0);
    end
  end

  task automatic write_reg(reg_index_t idx, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_STICK_CENTER: set_center = val;
      REG_YAW_DEADBAND: set_dband  = val;
      REG_YAW_RATE:     set_rate   = val;
      REG_P_GAIN:       set_p      = val;
      REG_I_GAIN:       set_i      = val;
      REG_D_GAIN:       set_d      = val;
      REG_CLAMP_ENABLE: set_clamp  = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(int c, int db, int rt, int p, int i, int d, int cl);
    write_reg(REG_STICK_CENTER, c);
    write_reg(REG_YAW_DEADBAND, db);
    write_reg(REG_YAW_RATE, rt);
    write_reg(REG_P_GAIN, p);
    write_reg(REG_I_GAIN, i);
    write_reg(REG_D_GAIN, d);
    write_reg(REG_CLAMP_ENABLE, cl);
    n_settings++;
  endtask

  task automatic add_req(int stick, int thr, int gyro, bit arm);
    yaw_req_t r;
    r.stick = stick[STICK_W-1:0];
    r.thr   = thr[THR_W-1:0];
    r.gyro  = gyro[GYRO_W-1:0];
    r.arm   = arm;
    r.drain = 1'b0;
    stick_req_q.push_back(r);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (stick_req_q.size() != 0 || tx_on || tx_armed || drive_exp_q.size() != 0);
  endtask

  // flight: armed, steady stick; landing: throttle near idle; otherwise raw noise
  function automatic yaw_req_t rand_req(int mode, int bstick, int bgyro, bit drain);
    yaw_req_t r;
    int s, g;
    s = bstick + int'($urandom_range(40, 0)) - 20;
    g = bgyro + int'($urandom_range(60, 0)) - 30;
    if ($urandom_range(11, 0) == 0) begin
      g = int'($urandom_range(2000, 641));
      if ($urandom_range(1, 0) != 0) g = -g;
    end
    if (mode < 65) begin
      r.arm = ($urandom_range(49, 0) != 0);
      r.thr = THR_W'($urandom_range(2000, 1300));
    end else if (mode < 80) begin
      r.arm = 1'($urandom_range(1, 0));
      r.thr = THR_W'($urandom_range(1400, 900));
    end else begin
      s = $urandom_range(4095, 0);
      g = int'($urandom);
      r.arm = 1'($urandom_range(1, 0));
      r.thr = THR_W'($urandom_range(4095, 0));
    end
    r.stick = s[STICK_W-1:0];
    r.gyro  = g[GYRO_W-1:0];
    r.drain = drain || ($urandom_range(49, 0) == 0);
    return r;
  endfunction

  initial begin
    int n, mode, blen, bstick, bgyro, base;
    cfg_we = 1'b0;
    cfg_index = REG_STICK_CENTER;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.yaw_stick = '0;
    sample_ch.throttle_raw = '0;
    sample_ch.gyro_yaw = '0;
    sample_ch.armed = 1'b0;
    result_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values, field extremes, clearing and gyro wrap
    add_req(1500, 1000, 0, 0);
    add_req(0, 1299, 0, 1);
    add_req(4095, 1300, 100, 1);
    add_req(2000, 4095, 640, 1);
    add_req(1000, 1800, -640, 1);
    add_req(1499, 1800, 641, 1);
    add_req(1501, 1800, -641, 1);
    add_req(1500, 1800, 32767, 1);
    add_req(1500, 1800, -32768, 1);
    add_req(2001, 1800, 32767, 1);
    add_req(999, 1800, -32768, 1);
    add_req(4095, 0, -1, 1);
    add_req(0, 4095, 1, 0);
    add_req(2000, 1500, 0, 1);
    repeat (6) add_req(2000, 1600, 0, 1);
    add_req(1000, 1600, -100, 1);
    add_req(1000, 1200, 200, 1);
    wait_idle();

    for (int ph = 1; ph <= 9; ph++) begin
      case (ph)
        1: begin
          program_regs(1000, 0, 0, 1, 0, 0, 0);
          send_gap_max = 10; recv_gap_max = 10;
        end
        2: begin
          program_regs(2000, 100, 100, 200, 250, 100, 1);
          send_gap_max = 0; recv_gap_max = 0;
        end
        3: begin
          program_regs(2047, 127, 127, 0, 255, 127, 1);
          send_gap_max = 10; recv_gap_max = 0;
        end
        4: begin
          program_regs(0, 0, 0, 0, 0, 0, 0);
          send_gap_max = 0; recv_gap_max = 10;
        end
        default: begin
          program_regs($urandom_range(2000, 1000), $urandom_range(100, 0),
                       $urandom_range(100, 0), $urandom_range(200, 1),
                       $urandom_range(250, 0), $urandom_range(100, 0), $urandom_range(1, 0));
          send_gap_max = $urandom_range(1, 0) * 10;
          recv_gap_max = $urandom_range(1, 0) * 10;
        end
      endcase
      base = req_cnt;
      n = 0;
      while (n < 100) begin
        mode   = $urandom_range(99, 0);
        blen   = $urandom_range(40, 4);
        bstick = set_center + int'($urandom_range(1200, 0)) - 600;
        bstick = clamp_int(bstick, 20, 4075);
        bgyro  = int'($urandom_range(300, 0)) - 150;
        repeat (blen) begin
          stick_req_q.push_back(rand_req(mode, bstick, bgyro, n == 50));
          n++;
        end
      end
      if (ph == 3) begin
        while (req_cnt < base + 20) @(posedge clk);
        hold_kicks++;
      end
      wait_idle();
    end

    repeat (400) @(posedge clk);
    if (drive_exp_q.size() != 0) fail_cnt++;
    $display("covered %0d control cycles over %0d register settings, %0d results checked",
             req_cnt, n_settings, res_cnt);
    $display("integrator at limit %0d times, cleared %0d times, output limited %0d times",
             n_isat, n_clear, n_olim);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
